[sv/kvca_pkg.sv]
// ----------------------------------------------------------------------------
// kvca_pkg
// Shared types and constants for the keyed value cache aggregator.
// ----------------------------------------------------------------------------
package kvca_pkg;

  localparam int unsigned KVCA_ENTRIES = 32;
  localparam logic [7:0]  KVCA_RELOAD_RST = 8'd8;

  // Action codes
  localparam logic [1:0] ACT_UPDATE  = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  // Query modes
  localparam logic [2:0] MODE_ANY = 3'd0;
  localparam logic [2:0] MODE_MIN = 3'd1;
  localparam logic [2:0] MODE_MAX = 3'd2;
  localparam logic [2:0] MODE_SUM = 3'd3;
  localparam logic [2:0] MODE_AVG = 3'd4;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] key;
    logic [7:0]  lifetime;
    logic [63:0] value;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_APPEND,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

endpackage

[sv/kvca_ram.sv]
// ----------------------------------------------------------------------------
// kvca_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kvca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/keyed_value_cache_aggregator_unit.sv]
// ----------------------------------------------------------------------------
// keyed_value_cache_aggregator_unit
// Cache of signed 64-bit values keyed by source address and key hash, with
// lifetime aging and keyed aggregate queries.
// ----------------------------------------------------------------------------
// Each input transfer carries one action (update, tick, query or an unknown
// code) and yields exactly one result transfer. Entries live in a single RAM
// in insertion order; a small sequencer walks it entry by entry: a read state
// issues the read and a check state uses the registered data. An update on an
// empty table appends at once; otherwise it scans until a match, or appends
// after a full scan. A tick and a query scan every stored entry, and an
// average query then runs the bit-serial divider (one quotient bit per
// cycle). A result waiting on the output holds the sequencer in its last
// step. No clearing pass is needed: only entries below the fill count are
// ever read. The lifetime reload register may be written on the config
// channel while the unit idles.
module keyed_value_cache_aggregator_unit
  import kvca_pkg::*;
#(
  parameter int unsigned ENTRIES = KVCA_ENTRIES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i,       // lifetime_reload
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // source_ip[31:0], key[63:32], value[127:64]
  input  logic [4:0]   s_axis_tuser_i,   // action[1:0], agg_mode[4:2]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [71:0]  m_axis_tdata_o,   // agg_value[63:0], match_count[69:64], zero pad
  output logic [0:0]   m_axis_tuser_o    // status[0]
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  state_e state_q, state_d;

  logic [7:0]    reload_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] wptr_q, wptr_d;
  logic [CW-1:0] n_q, n_d;

  logic [1:0]  act_q, act_d;
  logic [2:0]  mode_q, mode_d;
  logic [31:0] ip_q, ip_d;
  logic [31:0] key_q, key_d;
  logic [63:0] val_q, val_d;
  logic        stat_q, stat_d;
  logic [63:0] first_q, first_d;
  logic [63:0] best_q, best_d;
  logic [63:0] sum_q, sum_d;

  // divider state
  logic [63:0] quo_q, quo_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic        neg_q, neg_d;
  logic [CW:0] dtrial;

  // output register
  logic        ovalid_q, ovalid_d;
  logic        ostat_q, ostat_d;
  logic [63:0] oagg_q, oagg_d;
  logic [5:0]  ocnt_q, ocnt_d;

  // RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  logic [7:0]  life_dec;
  logic        last_idx;
  logic [31:0] n_ext;

  kvca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  assign ram_rdata       = entry_t'(ram_rbits);
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {2'b00, ocnt_q, oagg_q};
  assign m_axis_tuser_o  = ostat_q;

  assign ram_raddr = idx_q[IW-1:0];
  assign life_dec  = ram_rdata.lifetime - 8'd1;
  assign last_idx  = ((idx_q + CW'(1)) == count_q);
  assign n_ext     = 32'(n_q);
  assign dtrial    = {rem_q, quo_q[63]};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    wptr_d   = wptr_q;
    n_d      = n_q;
    act_d    = act_q;
    mode_d   = mode_q;
    ip_d     = ip_q;
    key_d    = key_q;
    val_d    = val_q;
    stat_d   = stat_q;
    first_d  = first_q;
    best_d   = best_q;
    sum_d    = sum_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    neg_d    = neg_q;
    ovalid_d = ovalid_q;
    ostat_d  = ostat_q;
    oagg_d   = oagg_q;
    ocnt_d   = ocnt_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IW-1:0];
    ram_wdata = '{address: ip_q, key: key_q, lifetime: reload_q, value: val_q};

    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          act_d   = s_axis_tuser_i[1:0];
          mode_d  = s_axis_tuser_i[4:2];
          ip_d    = s_axis_tdata_i[31:0];
          key_d   = s_axis_tdata_i[63:32];
          val_d   = s_axis_tdata_i[127:64];
          idx_d   = '0;
          wptr_d  = '0;
          n_d     = '0;
          sum_d   = '0;
          stat_d  = 1'b0;
          if (s_axis_tuser_i[1:0] == ACT_UPDATE && count_q == '0) begin
            state_d = ST_APPEND;
          end else if (s_axis_tuser_i[1:0] == ACT_UNKNOWN || count_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        idx_d   = idx_q + CW'(1);
        state_d = last_idx ? ST_FINISH : ST_READ;
        unique case (act_q)
          ACT_UPDATE: begin
            if (ram_rdata.address == ip_q && ram_rdata.key == key_q) begin
              ram_we  = 1'b1;
              state_d = ST_FINISH;
            end else if (last_idx) begin
              state_d = ST_APPEND;
            end
          end
          ACT_TICK: begin
            // keep survivors packed: write each at the next free slot
            if (life_dec != 8'd0) begin
              ram_we    = 1'b1;
              ram_waddr = wptr_q[IW-1:0];
              ram_wdata = '{address: ram_rdata.address, key: ram_rdata.key,
                            lifetime: life_dec, value: ram_rdata.value};
              wptr_d    = wptr_q + CW'(1);
            end
            if (last_idx) begin
              count_d = (life_dec != 8'd0) ? wptr_q + CW'(1) : wptr_q;
            end
          end
          default: begin
            if (ram_rdata.key == key_q) begin
              n_d   = n_q + CW'(1);
              sum_d = sum_q + ram_rdata.value;
              if (n_q == '0) begin
                first_d = ram_rdata.value;
                best_d  = ram_rdata.value;
              end else if (mode_q == MODE_MIN &&
                           $signed(ram_rdata.value) < $signed(best_q)) begin
                best_d = ram_rdata.value;
              end else if (mode_q == MODE_MAX &&
                           $signed(ram_rdata.value) > $signed(best_q)) begin
                best_d = ram_rdata.value;
              end
            end
            if (last_idx && mode_q == MODE_AVG) begin
              state_d = ST_DIVIDE;
              neg_d   = sum_d[63];
              quo_d   = sum_d[63] ? (64'd0 - sum_d) : sum_d;
              rem_d   = '0;
              dcnt_d  = '0;
            end
          end
        endcase
      end
      ST_APPEND: begin
        if (count_q < CW'(ENTRIES)) begin
          ram_we    = 1'b1;
          ram_waddr = count_q[IW-1:0];
          count_d   = count_q + CW'(1);
        end else begin
          stat_d = 1'b1;
        end
        state_d = ST_FINISH;
      end
      ST_DIVIDE: begin
        // restoring division, one quotient bit per cycle
        if (n_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          if (dtrial >= {1'b0, n_q}) begin
            rem_d = CW'(dtrial - {1'b0, n_q});
            quo_d = {quo_q[62:0], 1'b1};
          end else begin
            rem_d = dtrial[CW-1:0];
            quo_d = {quo_q[62:0], 1'b0};
          end
          dcnt_d = dcnt_q + 6'd1;
          if (dcnt_q == 6'd63) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          ostat_d  = stat_q;
          oagg_d   = '0;
          ocnt_d   = '0;
          if (act_q == ACT_QUERY) begin
            ocnt_d = (n_ext > 32'd63) ? 6'd63 : n_ext[5:0];
            if (n_q != '0) begin
              case (mode_q)
                MODE_ANY: oagg_d = first_q;
                MODE_MIN, MODE_MAX: oagg_d = best_q;
                MODE_SUM: oagg_d = sum_q;
                MODE_AVG: oagg_d = neg_q ? (64'd0 - quo_q) : quo_q;
                default:  oagg_d = '0;
              endcase
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      reload_q <= KVCA_RELOAD_RST;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        reload_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    wptr_q  <= wptr_d;
    n_q     <= n_d;
    act_q   <= act_d;
    mode_q  <= mode_d;
    ip_q    <= ip_d;
    key_q   <= key_d;
    val_q   <= val_d;
    stat_q  <= stat_d;
    first_q <= first_d;
    best_q  <= best_d;
    sum_q   <= sum_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dcnt_q  <= dcnt_d;
    neg_q   <= neg_d;
    ostat_q <= ostat_d;
    oagg_q  <= oagg_d;
    ocnt_q  <= ocnt_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("fill count above table depth");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CHECK || state_q == ST_APPEND))
    else $error("table written outside scan or append");

  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result raised outside finish");

endmodule

[sim/tb_keyed_value_cache_aggregator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_value_cache_aggregator_unit
// Self-checking bench for the keyed value cache: a local predictor of the
// table tracks updates, ticks and queries, and every result transfer is
// compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_keyed_value_cache_aggregator_unit;
  import kvca_pkg::*;

  localparam int unsigned N_ENT = KVCA_ENTRIES;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  mode;
    logic [31:0] addr;
    logic [31:0] key;
    logic [63:0] value;
  } op_t;

  typedef struct packed {
    logic        status;
    logic [63:0] agg;
    logic [5:0]  count;
  } res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic [4:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [71:0]  m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  keyed_value_cache_aggregator_unit u_top (.*);

  always #4 clk_i = ~clk_i;

  // Predicted table contents, insertion order.
  logic [31:0] tbl_addr[$];
  logic [31:0] tbl_key[$];
  logic [7:0]  tbl_life[$];
  logic [63:0] tbl_val[$];
  logic [7:0]  reload_q = KVCA_RELOAD_RST;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   send_idle_pct = 0, recv_idle_pct = 0;
  int   n_mismatch = 0, n_results = 0;

  // Apply one operation to the predicted table and return its result.
  function automatic res_t apply_op(op_t op);
    res_t r;
    int hit, n;
    logic signed [63:0] best, d;
    logic [63:0] first, sum;
    r = '0;
    case (op.action)
      ACT_UPDATE: begin
        hit = -1;
        foreach (tbl_addr[i])
          if (hit < 0 && tbl_addr[i] == op.addr && tbl_key[i] == op.key) hit = i;
        if (hit >= 0) begin
          tbl_life[hit] = reload_q;
          tbl_val[hit]  = op.value;
        end else if (tbl_addr.size() < N_ENT) begin
          tbl_addr.push_back(op.addr);
          tbl_key.push_back(op.key);
          tbl_life.push_back(reload_q);
          tbl_val.push_back(op.value);
        end else begin
          r.status = 1'b1;
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < tbl_addr.size();) begin
          tbl_life[i] = tbl_life[i] - 8'd1;
          if (tbl_life[i] == 0) begin
            tbl_addr.delete(i); tbl_key.delete(i);
            tbl_life.delete(i); tbl_val.delete(i);
          end else i++;
        end
      end
      ACT_QUERY: begin
        n = 0; best = 0; first = 0; sum = 0;
        foreach (tbl_key[i]) begin
          if (tbl_key[i] != op.key) continue;
          d = tbl_val[i];
          if (n == 0) begin
            first = tbl_val[i]; best = d;
          end else if (op.mode == MODE_MIN && d < best) best = d;
          else if (op.mode == MODE_MAX && d > best) best = d;
          sum += tbl_val[i];
          n++;
        end
        if (n > 0) begin
          case (op.mode)
            MODE_ANY: r.agg = first;
            MODE_MIN, MODE_MAX: r.agg = best;
            MODE_SUM: r.agg = sum;
            MODE_AVG: r.agg = $signed(sum) / $signed(64'(n));
            default: r.agg = '0;
          endcase
        end
        r.count = (n > 63) ? 6'd63 : 6'(n);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: advance to the next pending op once the current one transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (s_axis_tvalid_i)
          expected_results.push_back(apply_op(
            op_t'({s_axis_tuser_i[1:0], s_axis_tuser_i[4:2], s_axis_tdata_i[31:0],
                   s_axis_tdata_i[63:32], s_axis_tdata_i[127:64]})));
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          op_t op;
          op = pending_ops.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {op.value, op.key, op.addr};
          s_axis_tuser_i  <= {op.mode, op.action};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{status: m_axis_tuser_o[0], agg: m_axis_tdata_o[63:0],
              count: m_axis_tdata_o[69:64]};
      n_results++;
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r || m_axis_tdata_o[71:70] !== 2'b00) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected %p got %p pad %b", exp_r, got,
                     m_axis_tdata_o[71:70]);
        end
      end
    end
  end

  function automatic op_t mk(logic [1:0] a, logic [31:0] ip, logic [31:0] k,
                             logic [63:0] v, logic [2:0] m);
    return '{action: a, mode: m, addr: ip, key: k, value: v};
  endfunction

  // Random op biased toward a small pool of keys and addresses so queries hit.
  function automatic op_t rand_op();
    op_t op;
    int sel;
    sel = $urandom_range(99);
    op.addr  = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(5));
    op.key   = ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(3));
    op.value = ($urandom_range(3) == 0) ? {$urandom, $urandom}
             : 64'($signed($urandom_range(200)) - 100);
    op.mode  = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                        : 3'($urandom_range(4));
    op.action = (sel < 55) ? ACT_UPDATE : (sel < 70) ? ACT_TICK
              : (sel < 98) ? ACT_QUERY : ACT_UNKNOWN;
    return op;
  endfunction

  task automatic drain();
    wait (pending_ops.size() == 0 && !s_axis_tvalid_i && expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reload(logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reload_q = v;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 28; recv_idle_pct = 63;
    // Directed: extremes, every action and mode, no match, table full.
    pending_ops.push_back(mk(ACT_QUERY, 0, 32'h1, 0, MODE_AVG));
    pending_ops.push_back(mk(ACT_UPDATE, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF, 0));
    pending_ops.push_back(mk(ACT_UPDATE, 0, '1, 64'h7FFF_FFFF_FFFF_FFFF, 0));
    pending_ops.push_back(mk(ACT_UPDATE, 1, '1, 64'h8000_0000_0000_0000, 7));
    pending_ops.push_back(mk(ACT_UPDATE, 2, '1, -64'sd7, 0));
    for (int m = 0; m < 8; m++) pending_ops.push_back(mk(ACT_QUERY, '1, '1, '1, 3'(m)));
    pending_ops.push_back(mk(ACT_UNKNOWN, '1, '1, '1, '1));
    for (int i = 0; i < 34; i++)
      pending_ops.push_back(mk(ACT_UPDATE, 32'(i + 10), 32'h5, 64'(i), 0));
    for (int m = 0; m < 5; m++) pending_ops.push_back(mk(ACT_QUERY, 0, 32'h5, 0, 3'(m)));
    for (int i = 0; i < 8; i++) pending_ops.push_back(mk(ACT_TICK, 0, 0, 0, 0));
    drain();
    write_reload(8'd255);
    for (int i = 0; i < 250; i++) pending_ops.push_back(rand_op());
    drain();
    write_reload(8'd1);
    send_idle_pct = 63; recv_idle_pct = 28;
    for (int i = 0; i < 150; i++) pending_ops.push_back(rand_op());
    drain();
    write_reload(8'd0);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 120; i++) pending_ops.push_back(rand_op());
    drain();
    write_reload(8'd3);
    for (int i = 0; i < 180; i++) pending_ops.push_back(rand_op());
    drain();
    $display("ran directed and ~700 random updates/ticks/queries over reloads 255,1,0,3");
    $display("results checked: %0d, mismatches: %0d", n_results, n_mismatch);
    if (n_mismatch == 0 && expected_results.size() == 0)
      $display("tb_keyed_value_cache_aggregator_unit: clean");
    else
      $display("tb_keyed_value_cache_aggregator_unit: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_keyed_value_cache_aggregator_unit: errors");
    $finish;
  end
endmodule
